>>> sv/vcs_pkg.sv
// vcs_pkg: shared types, constants and codes for the velocity command shaper.
// Used by vcs_front, vcs_queue, vcs_back and velocity_command_shaper.
// No dependencies.
package vcs_pkg;

  localparam int unsigned MAX_VALID_DT_US_DEF      = 150000;
  localparam int unsigned MIN_VALID_DT_US_DEF      = 100;
  localparam int unsigned KICK_MAX_DURATION_US_DEF = 200000;

  localparam int unsigned QUEUE_DEPTH = 4;

  // 2*pi in Q3.29
  localparam logic [31:0] TWO_PI_Q29         = 32'd3373259426;
  localparam logic [31:0] OMEGA_DEADBAND_LSB = 32'd10;
  localparam logic [31:0] KICK_MIN_TARGET    = 32'd65;
  localparam logic [40:0] TERM_CAP           = 41'h100_0000_0000;
  localparam logic [19:0] USEC_PER_S         = 20'd1000000;
  localparam logic [15:0] CUTOFF_RESET       = 16'd52429;

  // numerator |diff|*1e6 width
  localparam int unsigned NUM_W = 53;

  typedef enum logic [3:0] {
    REG_INERTIA   = 4'd0,
    REG_VISCOUS   = 4'd1,
    REG_STATIC    = 4'd2,
    REG_CUTOFF    = 4'd3,
    REG_KICK_SPD  = 4'd4,
    REG_RETRIGGER = 4'd5,
    REG_REST      = 4'd6,
    REG_KICK_MAX  = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [31:0] inertia;
    logic [31:0] viscous_friction;
    logic [31:0] static_friction;
    logic [15:0] cutoff_fraction;
    logic [30:0] kick_speed;
    logic [30:0] retrigger_delta;
    logic [30:0] rest_threshold;
    logic [30:0] kick_max_target;
  } cfg_t;

  // one classified command, front to back
  typedef struct packed {
    logic        torque_en;
    logic        dneg;
    logic [32:0] dmag;
    logic [31:0] dt;
    logic        tneg;
    logic [31:0] tmag;
    logic [31:0] eff;
    logic        kick;
  } job_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_NUM,
    B_DIV,
    B_MUL,
    B_SUM,
    B_OUT
  } back_state_t;

endpackage

>>> sv/vcs_queue.sv
// vcs_queue: short FIFO of classified commands between front and back.
// Depends on vcs_pkg (job_t, QUEUE_DEPTH).
module vcs_queue #(
  parameter int unsigned DEPTH = vcs_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vcs_pkg::job_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output vcs_pkg::job_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  vcs_pkg::job_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/vcs_front.sv
// vcs_front: accepts commands, keeps history and kick state, classifies each
// command into a job for the torque back end. Depends on vcs_pkg.
module vcs_front #(
  parameter int unsigned MAX_VALID_DT_US      = vcs_pkg::MAX_VALID_DT_US_DEF,
  parameter int unsigned MIN_VALID_DT_US      = vcs_pkg::MIN_VALID_DT_US_DEF,
  parameter int unsigned KICK_MAX_DURATION_US = vcs_pkg::KICK_MAX_DURATION_US_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  vcs_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          kind,
  input  logic [31:0]   target_velocity,
  input  logic [31:0]   measured_velocity,
  input  logic [31:0]   timestamp_us,
  input  logic          full,
  output logic          push,
  output vcs_pkg::job_t push_data
);

  logic [31:0] last_target;
  logic [31:0] last_time;
  logic        history_valid;
  logic [31:0] pursued_target;
  logic        kicking;
  logic [31:0] kick_start;

  logic [32:0] diff;
  logic [32:0] dmag;
  logic [31:0] dt;
  logic        dt_ok;
  logic [31:0] tmag;
  logic [31:0] pmag;
  logic [31:0] mmag;
  logic [32:0] pdiff;
  logic [32:0] change;
  logic        retrig;
  logic        kick_new;
  logic        kick_cur;
  logic [31:0] start_cur;
  logic [47:0] meas_scaled;
  logic [47:0] tgt_scaled;
  logic        reached;
  logic        expired;
  logic        kick_out;
  logic [31:0] kick_val;

  assign in_stall = full;
  assign push     = in_valid && !full;

  always_comb begin
    diff   = {target_velocity[31], target_velocity} - {last_target[31], last_target};
    dmag   = diff[32] ? (33'd0 - diff) : diff;
    dt     = timestamp_us - last_time;
    dt_ok  = (dt > 32'(MIN_VALID_DT_US)) && (dt <= 32'(MAX_VALID_DT_US));
    tmag   = target_velocity[31] ? (32'd0 - target_velocity) : target_velocity;
    pmag   = pursued_target[31] ? (32'd0 - pursued_target) : pursued_target;
    mmag   = measured_velocity[31] ? (32'd0 - measured_velocity) : measured_velocity;
    pdiff  = {target_velocity[31], target_velocity} - {pursued_target[31], pursued_target};
    change = pdiff[32] ? (33'd0 - pdiff) : pdiff;
    retrig = change > {2'b00, cfg.retrigger_delta};

    kick_new = (pmag < {1'b0, cfg.rest_threshold}) && (tmag > pmag)
            && (tmag > vcs_pkg::KICK_MIN_TARGET) && (tmag < {1'b0, cfg.kick_max_target});
    kick_cur  = retrig ? kick_new : kicking;
    start_cur = (retrig && kick_new) ? timestamp_us : kick_start;

    meas_scaled = {mmag, 16'd0};
    tgt_scaled  = {16'd0, tmag} * {32'd0, cfg.cutoff_fraction};
    reached     = meas_scaled >= tgt_scaled;
    expired     = (timestamp_us - start_cur) >= 32'(KICK_MAX_DURATION_US);
    kick_out    = kick_cur && !reached && !expired;
    // zero target counts as positive
    kick_val    = target_velocity[31] ? (32'd0 - {1'b0, cfg.kick_speed})
                                      : {1'b0, cfg.kick_speed};
  end

  always_comb begin
    push_data = '0;
    if (!kind) begin
      push_data.torque_en = (cfg.inertia != '0) && history_valid && dt_ok;
      push_data.dneg      = diff[32];
      push_data.dmag      = dmag;
      push_data.dt        = dt;
      push_data.tneg      = target_velocity[31];
      push_data.tmag      = tmag;
      push_data.eff       = kick_out ? kick_val : target_velocity;
      push_data.kick      = kick_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_target    <= '0;
      last_time      <= '0;
      history_valid  <= 1'b0;
      pursued_target <= '0;
      kicking        <= 1'b0;
      kick_start     <= '0;
    end else if (push) begin
      if (kind) begin
        last_target    <= '0;
        last_time      <= '0;
        history_valid  <= 1'b0;
        pursued_target <= '0;
        kicking        <= 1'b0;
        kick_start     <= '0;
      end else begin
        last_target   <= target_velocity;
        last_time     <= timestamp_us;
        history_valid <= 1'b1;
        kicking       <= kick_out;
        kick_start    <= start_cur;
        if (retrig) begin
          pursued_target <= target_velocity;
        end
      end
    end
  end

endmodule

>>> sv/vcs_back.sv
// vcs_back: torque sequencer. Bit-serial divider for acceleration, one
// shared 32x32 multiplier for the scaled products, output register.
// Depends on vcs_pkg.
module vcs_back (
  input  logic          clk,
  input  logic          rst,
  input  vcs_pkg::cfg_t cfg,
  input  logic          empty,
  input  vcs_pkg::job_t head,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [31:0]   effective_velocity,
  output logic [31:0]   torque_feedforward,
  output logic          kick_active
);

  localparam int unsigned CNT_W = $clog2(vcs_pkg::NUM_W);
  localparam logic [95:0] RND16 = 96'd1 << 15;
  localparam logic [95:0] RND37 = 96'd1 << 36;

  vcs_pkg::back_state_t state, state_next;
  vcs_pkg::job_t job;

  logic [vcs_pkg::NUM_W-1:0] num;
  logic [32:0]      rem;
  logic [CNT_W-1:0] cnt;
  logic [1:0]       mop;
  logic [1:0]       half;
  logic [95:0]      acc;
  logic [63:0]      inter;
  logic [40:0]      t1;
  logic [40:0]      t2;
  logic [31:0]      torque;

  logic        out_free;
  logic [32:0] trial;
  logic        qbit;
  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;
  logic [95:0] sum16;
  logic [95:0] sum37;
  logic [58:0] r37;
  logic [40:0] capped;
  logic [24:0] t3;
  logic signed [43:0] s1;
  logic signed [43:0] s2;
  logic signed [43:0] s3;
  logic signed [43:0] total;
  logic [31:0] sat;

  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      vcs_pkg::B_IDLE: if (!empty) begin
        state_next = head.torque_en ? vcs_pkg::B_NUM : vcs_pkg::B_OUT;
      end
      vcs_pkg::B_NUM: state_next = vcs_pkg::B_DIV;
      vcs_pkg::B_DIV: if (cnt == CNT_W'(vcs_pkg::NUM_W - 1)) begin
        state_next = vcs_pkg::B_MUL;
      end
      vcs_pkg::B_MUL: if (mop == 2'd3 && half == 2'd2) begin
        state_next = vcs_pkg::B_SUM;
      end
      vcs_pkg::B_SUM: state_next = vcs_pkg::B_OUT;
      vcs_pkg::B_OUT: if (out_free) begin
        state_next = vcs_pkg::B_IDLE;
      end
      default: state_next = vcs_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop = (state == vcs_pkg::B_IDLE) && !empty;
  end

  always_comb begin
    trial = {rem[31:0], num[vcs_pkg::NUM_W-1]};
    qbit  = trial >= {1'b0, job.dt};

    unique case (mop)
      2'd0: begin
        mul_a = {{(64 - vcs_pkg::NUM_W){1'b0}}, num};
        mul_b = vcs_pkg::TWO_PI_Q29;
      end
      2'd1: begin
        mul_a = inter;
        mul_b = cfg.inertia;
      end
      2'd2: begin
        mul_a = {32'd0, job.tmag};
        mul_b = vcs_pkg::TWO_PI_Q29;
      end
      default: begin
        mul_a = inter;
        mul_b = cfg.viscous_friction;
      end
    endcase
    prod = {32'd0, (half == 2'd0) ? mul_a[31:0] : mul_a[63:32]} * {32'd0, mul_b};

    sum16  = acc + RND16;
    sum37  = acc + RND37;
    r37    = sum37[95:37];
    capped = (r37 > {18'd0, vcs_pkg::TERM_CAP}) ? vcs_pkg::TERM_CAP : r37[40:0];

    t3 = 25'(({1'b0, cfg.static_friction} + 33'd128) >> 8);
    s1 = job.dneg ? -$signed({3'b000, t1}) : $signed({3'b000, t1});
    s2 = job.tneg ? -$signed({3'b000, t2}) : $signed({3'b000, t2});
    if (job.tmag > vcs_pkg::OMEGA_DEADBAND_LSB) begin
      s3 = job.tneg ? -$signed({19'd0, t3}) : $signed({19'd0, t3});
    end else begin
      s3 = '0;
    end
    total = s1 + s2 + s3;
    if (total > 44'sd2147483647) begin
      sat = 32'h7FFF_FFFF;
    end else if (total < -44'sd2147483648) begin
      sat = 32'h8000_0000;
    end else begin
      sat = total[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vcs_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      vcs_pkg::B_IDLE: begin
        job    <= head;
        torque <= '0;
      end
      vcs_pkg::B_NUM: begin
        num <= {20'd0, job.dmag} * {33'd0, vcs_pkg::USEC_PER_S};
        rem <= '0;
        cnt <= '0;
      end
      vcs_pkg::B_DIV: begin
        rem  <= qbit ? (trial - {1'b0, job.dt}) : trial;
        num  <= {num[vcs_pkg::NUM_W-2:0], qbit};
        cnt  <= cnt + 1'b1;
        mop  <= '0;
        half <= '0;
      end
      vcs_pkg::B_MUL: begin
        unique case (half)
          2'd0: begin
            acc  <= {32'd0, prod};
            half <= 2'd1;
          end
          2'd1: begin
            acc  <= acc + {prod, 32'd0};
            half <= 2'd2;
          end
          default: begin
            if (!mop[0]) begin
              inter <= sum16[79:16];
            end else if (!mop[1]) begin
              t1 <= capped;
            end else begin
              t2 <= capped;
            end
            half <= 2'd0;
            mop  <= mop + 1'b1;
          end
        endcase
      end
      vcs_pkg::B_SUM: torque <= sat;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == vcs_pkg::B_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == vcs_pkg::B_OUT && out_free) begin
      effective_velocity <= job.eff;
      torque_feedforward <= torque;
      kick_active        <= job.kick;
    end
  end

endmodule

>>> sv/velocity_command_shaper.sv
// Velocity command shaper: torque feed-forward with breakaway kick.
// Sequence for a command with feed-forward: pop, numerator, bit-serial divider, four products
// on one 32x32 multiplier, sum, output load; stop items and commands without feed-forward go
// from pop straight to the output load.
// One item in the back end at a time; a stalled output fills the 4-entry queue, then in_stall.
// Reset (rst, synchronous): history, kick state and queue clear; registers to defaults.
module velocity_command_shaper #(
  parameter int unsigned MAX_VALID_DT_US      = vcs_pkg::MAX_VALID_DT_US_DEF,
  parameter int unsigned MIN_VALID_DT_US      = vcs_pkg::MIN_VALID_DT_US_DEF,
  parameter int unsigned KICK_MAX_DURATION_US = vcs_pkg::KICK_MAX_DURATION_US_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        kind,
  input  logic [31:0] target_velocity,
  input  logic [31:0] measured_velocity,
  input  logic [31:0] timestamp_us,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] effective_velocity,
  output logic [31:0] torque_feedforward,
  output logic        kick_active
);

  vcs_pkg::cfg_t cfg;
  vcs_pkg::job_t push_data;
  vcs_pkg::job_t head;
  logic push;
  logic full;
  logic pop;
  logic empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{inertia: '0, viscous_friction: '0, static_friction: '0,
               cutoff_fraction: vcs_pkg::CUTOFF_RESET, kick_speed: '0,
               retrigger_delta: '0, rest_threshold: '0, kick_max_target: '0};
    end else if (cfg_valid) begin
      unique case (vcs_pkg::reg_idx_t'(cfg_index))
        vcs_pkg::REG_INERTIA:   cfg.inertia          <= cfg_data;
        vcs_pkg::REG_VISCOUS:   cfg.viscous_friction <= cfg_data;
        vcs_pkg::REG_STATIC:    cfg.static_friction  <= cfg_data;
        vcs_pkg::REG_CUTOFF:    cfg.cutoff_fraction  <= cfg_data[15:0];
        vcs_pkg::REG_KICK_SPD:  cfg.kick_speed       <= cfg_data[30:0];
        vcs_pkg::REG_RETRIGGER: cfg.retrigger_delta  <= cfg_data[30:0];
        vcs_pkg::REG_REST:      cfg.rest_threshold   <= cfg_data[30:0];
        vcs_pkg::REG_KICK_MAX:  cfg.kick_max_target  <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  vcs_front #(
    .MAX_VALID_DT_US      (MAX_VALID_DT_US),
    .MIN_VALID_DT_US      (MIN_VALID_DT_US),
    .KICK_MAX_DURATION_US (KICK_MAX_DURATION_US)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .kind              (kind),
    .target_velocity   (target_velocity),
    .measured_velocity (measured_velocity),
    .timestamp_us      (timestamp_us),
    .full              (full),
    .push              (push),
    .push_data         (push_data)
  );

  vcs_queue #(
    .DEPTH (vcs_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .pop_data  (head)
  );

  vcs_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .empty              (empty),
    .head               (head),
    .pop                (pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .effective_velocity (effective_velocity),
    .torque_feedforward (torque_feedforward),
    .kick_active        (kick_active)
  );

endmodule
